[hdl/llr_pkg.sv]
package llr_pkg;

  localparam int COSINE_STAGES = 16;
  localparam int ATAN_LEN = 24;
  localparam int QUO_BITS = 17;
  // cosine pipe (stages plus rounding), numerator stages, divider, output register
  localparam int LATENCY = COSINE_STAGES + 1 + 5 + QUO_BITS + 1;

  localparam logic [15:0] RIGHT_ANGLE = 16'd23040;
  localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
  localparam logic signed [15:0] LIMB_RESET = 16'sd4096;
  localparam logic signed [15:0] FACTOR_MAX = 16'sd32767;
  localparam logic signed [15:0] FACTOR_MIN = -16'sd32768;

  // arctangent per stage, 2^-20 degree units
  localparam logic signed [28:0] ATAN_TBL [0:ATAN_LEN-1] = '{
    29'sd47185920, 29'sd27855475, 29'sd14718068, 29'sd7471121, 29'sd3750058,
    29'sd1876857, 29'sd938658, 29'sd469357, 29'sd234682, 29'sd117342,
    29'sd58671, 29'sd29335, 29'sd14668, 29'sd7334, 29'sd3667, 29'sd1833,
    29'sd917, 29'sd458, 29'sd229, 29'sd115, 29'sd57, 29'sd29, 29'sd14, 29'sd7
  };

  typedef struct packed {
    logic [15:0] incidence_angle;
    logic [15:0] emission_angle;
  } llr_req_t;

  typedef struct packed {
    logic signed [15:0] brightness_factor;
    logic               out_of_view;
    logic               saturated;
  } llr_res_t;

  typedef struct packed {
    logic signed [32:0] x;
    logic signed [32:0] y;
    logic signed [28:0] z;
  } cordic_t;

  // divider stage contents
  typedef struct packed {
    logic                  v;
    logic                  neg;
    logic                  oov;
    logic                  ovf;
    logic [16:0]           dsum;
    logic [49:0]           rem;
    logic [QUO_BITS-1:0]   quo;
  } llr_div_t;

  function automatic cordic_t cordic_step(cordic_t c, int i);
    logic signed [32:0] dx;
    logic signed [32:0] dy;
    cordic_t r;
    dx = c.y >>> i;
    dy = c.x >>> i;
    if (!c.z[28]) begin
      r.x = c.x - dx;
      r.y = c.y + dy;
      r.z = c.z - ATAN_TBL[i];
    end else begin
      r.x = c.x + dx;
      r.y = c.y - dy;
      r.z = c.z + ATAN_TBL[i];
    end
    return r;
  endfunction

endpackage

[hdl/lunar_lambert_reflectance_unit.sv]
// Throughput: one transaction per cycle; busy is never raised.
// The datapath runs through the cosine rotation stages, numerator stages and the 17-stage quotient pipeline.
// Reset (async, active low) clears all valid bits and sets limb weight to 1.0.
// The receiver cannot stall: each result strobes for exactly one cycle.
module lunar_lambert_reflectance_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  llr_pkg::llr_req_t  req_i,
  output logic               res_valid_o,
  output llr_pkg::llr_res_t  res_o,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [15:0]        cfg_data
);
  import llr_pkg::*;

  typedef struct packed {
    logic        v;
    logic        oov;
    logic [15:0] mu0;
    logic [16:0] dsum;
  } side_t;

  logic signed [15:0] limb_q;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limb_q <= LIMB_RESET;
    end else if (cfg_valid && cfg_ready) begin
      limb_q <= cfg_data;
    end
  end

  logic        cos_v;
  logic        cos_oov;
  logic [15:0] mu0;
  logic [15:0] mu;

  llr_cosine u_cosine (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start && !busy),
    .req_i   (req_i),
    .valid_o (cos_v),
    .oov_o   (cos_oov),
    .mu0_o   (mu0),
    .mu_o    (mu)
  );

  // num = mu0 * ((4096 - L) * d + L * 2^16), d = mu0 + mu
  side_t sa_q, sb_q, sc_q, sd_q;
  logic signed [16:0] wl_q;
  logic signed [34:0] p_q;
  logic               neg_c_q, neg_d_q;
  logic [32:0]        abs_q;
  logic [48:0]        num_q;
  logic signed [35:0] t_c;
  logic [49:0]        n_e;
  llr_div_t           div_in_q;
  llr_div_t           div_out;

  assign t_c = 36'(p_q) + (36'(limb_q) <<< 16);
  assign n_e = 50'(num_q) + (50'(sd_q.dsum) << 14);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sa_q     <= '0;
      sb_q     <= '0;
      sc_q     <= '0;
      sd_q     <= '0;
      wl_q     <= '0;
      p_q      <= '0;
      neg_c_q  <= 1'b0;
      abs_q    <= '0;
      neg_d_q  <= 1'b0;
      num_q    <= '0;
      div_in_q <= '0;
    end else begin
      sa_q.v    <= cos_v;
      sa_q.oov  <= cos_oov;
      sa_q.mu0  <= mu0;
      sa_q.dsum <= 17'(mu0) + 17'(mu);
      wl_q      <= 17'sd4096 - 17'(limb_q);
      sb_q.v    <= sa_q.v;
      sb_q.oov  <= sa_q.oov;
      sb_q.mu0  <= sa_q.mu0;
      sb_q.dsum <= sa_q.dsum;
      p_q       <= 35'(wl_q * $signed({1'b0, sa_q.dsum}));
      sc_q.v    <= sb_q.v;
      sc_q.oov  <= sb_q.oov;
      sc_q.mu0  <= sb_q.mu0;
      sc_q.dsum <= sb_q.dsum;
      neg_c_q   <= t_c[35];
      abs_q     <= t_c[35] ? 33'(-t_c) : 33'(t_c);
      sd_q.v    <= sc_q.v;
      sd_q.oov  <= sc_q.oov;
      sd_q.mu0  <= sc_q.mu0;
      sd_q.dsum <= sc_q.dsum;
      neg_d_q   <= neg_c_q;
      num_q     <= 49'(sc_q.mu0) * 49'(abs_q);
      div_in_q.v    <= sd_q.v;
      div_in_q.neg  <= neg_d_q;
      div_in_q.oov  <= sd_q.oov;
      div_in_q.ovf  <= n_e[49:32] >= 18'(sd_q.dsum);
      div_in_q.dsum <= sd_q.dsum;
      div_in_q.rem  <= n_e;
      div_in_q.quo  <= '0;
    end
  end

  llr_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .stage_i (div_in_q),
    .stage_o (div_out)
  );

  llr_res_t res_d, res_q;
  logic     res_valid_q;

  always_comb begin
    res_d = '0;
    if (div_out.oov) begin
      res_d.out_of_view = 1'b1;
    end else if (!div_out.neg) begin
      if (div_out.ovf || div_out.quo > 17'd32767) begin
        res_d.brightness_factor = FACTOR_MAX;
        res_d.saturated = 1'b1;
      end else begin
        res_d.brightness_factor = 16'(div_out.quo);
      end
    end else begin
      if (div_out.ovf || div_out.quo > 17'd32768) begin
        res_d.brightness_factor = FACTOR_MIN;
        res_d.saturated = 1'b1;
      end else begin
        res_d.brightness_factor = 16'(-div_out.quo);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= div_out.v;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

[hdl/llr_cosine.sv]
module llr_cosine (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  llr_pkg::llr_req_t req_i,
  output logic              valid_o,
  output logic              oov_o,
  output logic [15:0]       mu0_o,
  output logic [15:0]       mu_o
);
  import llr_pkg::*;

  cordic_t inc_q [COSINE_STAGES];
  cordic_t emi_q [COSINE_STAGES];
  logic    v_q   [COSINE_STAGES];
  logic    oov_q [COSINE_STAGES];

  logic    oov_in;
  cordic_t inc_init;
  cordic_t emi_init;

  assign oov_in = (req_i.incidence_angle >= RIGHT_ANGLE) ||
                  (req_i.emission_angle >= RIGHT_ANGLE);
  assign inc_init = '{x: CORDIC_X0, y: '0, z: {1'b0, req_i.incidence_angle, 12'b0}};
  assign emi_init = '{x: CORDIC_X0, y: '0, z: {1'b0, req_i.emission_angle, 12'b0}};

  for (genvar i = 0; i < COSINE_STAGES; i++) begin : g_stage
    if (i == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[i] <= 1'b0;
        end else begin
          v_q[i] <= valid_i;
        end
      end
      always_ff @(posedge clk_i) begin
        inc_q[i] <= cordic_step(inc_init, i);
        emi_q[i] <= cordic_step(emi_init, i);
        oov_q[i] <= oov_in;
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          v_q[i] <= 1'b0;
        end else begin
          v_q[i] <= v_q[i-1];
        end
      end
      always_ff @(posedge clk_i) begin
        inc_q[i] <= cordic_step(inc_q[i-1], i);
        emi_q[i] <= cordic_step(emi_q[i-1], i);
        oov_q[i] <= oov_q[i-1];
      end
    end
  end

  // Q2.30 -> Q1.15, round half up, clamp to [-1.0, 1.0]
  function automatic logic signed [16:0] cos_round(logic signed [32:0] x);
    logic signed [32:0] r;
    r = (x + 33'sd16384) >>> 15;
    if (r > 33'sd32768) begin
      return 17'sd32767 + 17'sd1;
    end else if (r < -33'sd32768) begin
      return -17'sd32768;
    end
    return 17'(r);
  endfunction

  logic signed [16:0] c0;
  logic signed [16:0] c1;
  logic               valid_q;
  logic               oov_out_q;
  logic [15:0]        mu0_q;
  logic [15:0]        mu_q;

  assign c0 = cos_round(inc_q[COSINE_STAGES-1].x);
  assign c1 = cos_round(emi_q[COSINE_STAGES-1].x);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= v_q[COSINE_STAGES-1];
    end
  end

  always_ff @(posedge clk_i) begin
    oov_out_q <= oov_q[COSINE_STAGES-1] || (c0 <= 17'sd0) || (c1 <= 17'sd0);
    mu0_q     <= c0[15:0];
    mu_q      <= c1[15:0];
  end

  assign valid_o = valid_q;
  assign oov_o   = oov_out_q;
  assign mu0_o   = mu0_q;
  assign mu_o    = mu_q;

endmodule

[hdl/llr_div.sv]
module llr_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  llr_pkg::llr_div_t stage_i,
  output llr_pkg::llr_div_t stage_o
);
  import llr_pkg::*;

  llr_div_t st_q [QUO_BITS];

  // restoring division, one quotient bit per stage, MSB first
  function automatic llr_div_t div_step(llr_div_t s, int k);
    logic [49:0] dvs;
    llr_div_t r;
    dvs = 50'(s.dsum) << (15 + k);
    r = s;
    if (s.rem >= dvs) begin
      r.rem    = s.rem - dvs;
      r.quo[k] = 1'b1;
    end
    return r;
  endfunction

  for (genvar j = 0; j < QUO_BITS; j++) begin : g_stage
    if (j == 0) begin : g_first
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          st_q[j] <= '0;
        end else begin
          st_q[j] <= div_step(stage_i, QUO_BITS - 1 - j);
        end
      end
    end else begin : g_next
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          st_q[j] <= '0;
        end else begin
          st_q[j] <= div_step(st_q[j-1], QUO_BITS - 1 - j);
        end
      end
    end
  end

  assign stage_o = st_q[QUO_BITS-1];

endmodule

[hdl/llr_checker.sv]
module llr_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              start,
  input logic              busy,
  input llr_pkg::llr_req_t req_i,
  input logic              res_valid_o,
  input llr_pkg::llr_res_t res_o
);
  import llr_pkg::*;

  // every accepted transaction yields exactly one result after fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(rst_ni, LATENCY) |-> (res_valid_o == $past(start && !busy, LATENCY)))
    else $error("result strobe does not match accepted transaction");

  a_oov_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.out_of_view |->
      (res_o.brightness_factor == 16'sd0) && !res_o.saturated)
    else $error("out of view result not zero");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.saturated |->
      (res_o.brightness_factor == FACTOR_MAX) || (res_o.brightness_factor == FACTOR_MIN))
    else $error("saturated result not at a rail");

  a_wide_angle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && $past(rst_ni, LATENCY) &&
    $past(start && ((req_i.incidence_angle >= RIGHT_ANGLE) ||
                    (req_i.emission_angle >= RIGHT_ANGLE)), LATENCY)
    |-> res_o.out_of_view)
    else $error("angle past ninety degrees not flagged");

endmodule

bind lunar_lambert_reflectance_unit llr_checker u_llr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);

[tb/lunar_lambert_reflectance_unit_tb.sv]
module lunar_lambert_reflectance_unit_tb;
  import llr_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int TAIL_CYCLES = LATENCY + 10;
  localparam logic [15:0] ANGLE_FULL = 16'd46080;

  logic      clk_i;
  logic      rst_ni;
  logic      start;
  logic      busy;
  llr_req_t  req_i;
  logic      res_valid_o;
  llr_res_t  res_o;
  logic      cfg_valid;
  logic      cfg_ready;
  logic [15:0] cfg_data;

  lunar_lambert_reflectance_unit DUT (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy), .req_i(req_i),
    .res_valid_o(res_valid_o), .res_o(res_o),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  typedef struct {
    logic [15:0] inc;
    logic [15:0] emi;
    logic        known;
    llr_res_t    res;
  } stim_row_t;

  logic signed [15:0] weight_model;
  llr_res_t           factor_q[$];
  int                 fail_cnt;
  int                 item_cnt;
  int                 res_cnt;
  int                 oov_cnt;
  int                 sat_cnt;
  int                 idle_cnt;
  bit                 no_idle;

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  function automatic longint shr_floor(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint cosine_q15(logic [15:0] a);
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint r;
    x = 652032874;
    y = 0;
    z = longint'(a) * 4096;
    for (int i = 0; i < COSINE_STAGES && i < ATAN_LEN; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(ATAN_TBL[i]);
      end else begin
        x += dx; y -= dy; z += longint'(ATAN_TBL[i]);
      end
    end
    r = shr_floor(x + (64'sd1 <<< 14), 15);
    if (r > 32768) r = 32768;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic llr_res_t predict_factor(logic [15:0] inc, logic [15:0] emi,
                                              logic signed [15:0] w);
    llr_res_t r;
    longint m0;
    longint m;
    longint d;
    longint num;
    longint den;
    longint q;
    longint unsigned mag;
    r = '0;
    if (inc >= RIGHT_ANGLE || emi >= RIGHT_ANGLE) begin
      r.out_of_view = 1'b1;
      return r;
    end
    m0 = cosine_q15(inc);
    m = cosine_q15(emi);
    if (m0 <= 0 || m <= 0) begin
      r.out_of_view = 1'b1;
      return r;
    end
    d = m0 + m;
    num = m0 * (4096 - longint'(w)) * d + longint'(w) * m0 * 65536;
    den = d * 32768;
    mag = (num < 0) ? longint'(-num) : num;
    mag = (mag * 2 + den) / (den * 2);
    if (mag > 40000) mag = 40000;
    q = (num < 0) ? -longint'(mag) : longint'(mag);
    if (q > 32767) begin q = 32767; r.saturated = 1'b1; end
    if (q < -32768) begin q = -32768; r.saturated = 1'b1; end
    r.brightness_factor = q[15:0];
    return r;
  endfunction

  // result checker and watchdog
  always @(posedge clk_i) begin
    llr_res_t exp_res;
    if (rst_ni) begin
      if (res_valid_o) begin
        res_cnt++;
        idle_cnt <= 0;
        if (factor_q.size() == 0) begin
          $error("unexpected result %h", res_o);
          fail_cnt++;
        end else begin
          exp_res = factor_q.pop_front();
          if (res_o.out_of_view) oov_cnt++;
          if (res_o.saturated) sat_cnt++;
          if (res_o.brightness_factor !== exp_res.brightness_factor) begin
            $error("brightness_factor expected %0d actual %0d",
                   exp_res.brightness_factor, res_o.brightness_factor);
            fail_cnt++;
          end
          if (res_o.out_of_view !== exp_res.out_of_view) begin
            $error("out_of_view expected %0b actual %0b",
                   exp_res.out_of_view, res_o.out_of_view);
            fail_cnt++;
          end
          if (res_o.saturated !== exp_res.saturated) begin
            $error("saturated expected %0b actual %0b",
                   exp_res.saturated, res_o.saturated);
            fail_cnt++;
          end
        end
      end else if (!(start && !busy) && !(cfg_valid && cfg_ready)) begin
        idle_cnt <= idle_cnt + 1;
        if (idle_cnt >= WATCHDOG_LIMIT) begin
          $display("timeout waiting for handshake");
          $display("== FAIL ==");
          $finish;
        end
      end else begin
        idle_cnt <= 0;
      end
    end
  end

  task automatic send_angles(logic [15:0] inc, logic [15:0] emi, bit check_known,
                             llr_res_t known_res);
    llr_res_t pred;
    while (!no_idle && $urandom_range(99) < 28) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= '{incidence_angle: inc, emission_angle: emi};
    do @(posedge clk_i); while (busy);
    pred = predict_factor(inc, emi, weight_model);
    if (check_known && pred !== known_res) begin
      $error("predictor disagrees with table: expected %h got %h", known_res, pred);
      fail_cnt++;
    end
    factor_q.push_back(check_known ? known_res : pred);
    item_cnt++;
  endtask

  task automatic drain_pipe();
    start <= 1'b0;
    while (factor_q.size() != 0) @(posedge clk_i);
    repeat (TAIL_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_weight(logic signed [15:0] w);
    cfg_valid <= 1'b1;
    cfg_data <= w;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    weight_model = w;
  endtask

  function automatic logic [15:0] pick_angle();
    int sel;
    sel = $urandom_range(99);
    if (sel < 75) return 16'($urandom_range(23039));
    if (sel < 85) return 16'($urandom_range(23039, 22900));
    if (sel < 95) return 16'($urandom_range(46080, 23040));
    return 16'($urandom_range(65535));
  endfunction

  stim_row_t directed_tbl[$];
  logic signed [15:0] weight_set[6];

  initial begin
    llr_res_t oov_res;
    llr_res_t zero_res;
    oov_res = '{brightness_factor: 16'sd0, out_of_view: 1'b1, saturated: 1'b0};
    zero_res = '0;
    start = 1'b0;
    req_i = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    rst_ni = 1'b0;
    fail_cnt = 0;
    item_cnt = 0;
    res_cnt = 0;
    oov_cnt = 0;
    sat_cnt = 0;
    idle_cnt = 0;
    no_idle = 1'b0;
    weight_model = LIMB_RESET;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: out-of-view rows have fixed results, others go to the predictor
    directed_tbl = '{
      '{16'd0, 16'd0, 1'b0, zero_res},
      '{16'd0, 16'd23039, 1'b0, zero_res},
      '{16'd23039, 16'd0, 1'b0, zero_res},
      '{16'd23039, 16'd23039, 1'b0, zero_res},
      '{16'd23000, 16'd100, 1'b0, zero_res},
      '{16'd11520, 16'd11520, 1'b0, zero_res},
      '{16'd15360, 16'd0, 1'b0, zero_res},
      '{16'd23040, 16'd0, 1'b1, oov_res},
      '{16'd0, 16'd23040, 1'b1, oov_res},
      '{ANGLE_FULL, ANGLE_FULL, 1'b1, oov_res},
      '{16'hFFFF, 16'hFFFF, 1'b1, oov_res},
      '{16'hAAAA, 16'h5555, 1'b1, oov_res},
      '{16'h5555, 16'hAAAA, 1'b1, oov_res},
      '{16'd5000, 16'd20000, 1'b0, zero_res}
    };
    foreach (directed_tbl[i])
      send_angles(directed_tbl[i].inc, directed_tbl[i].emi,
                  directed_tbl[i].known, directed_tbl[i].res);
    drain_pipe();

    weight_set = '{16'sd0, 16'sd32767, -16'sd32768, 16'sd2048, -16'sd4096, LIMB_RESET};
    foreach (weight_set[k]) begin
      write_weight(weight_set[k]);
      send_angles(16'd0, 16'd0, 1'b0, zero_res);
      send_angles(16'd23000, 16'd0, 1'b0, zero_res);
      send_angles(16'd0, 16'd23000, 1'b0, zero_res);
      drain_pipe();
    end

    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 0) write_weight(16'($urandom_range(65535)));
      else if (ph < 3) write_weight(16'($urandom_range(8192)));
      else write_weight(weight_set[$urandom_range(5)]);
      no_idle = (ph == 2);
      repeat (90) send_angles(pick_angle(), pick_angle(), 1'b0, zero_res);
      no_idle = 1'b0;
      drain_pipe();
    end

    $display("covered %0d transactions, %0d results, %0d out of view, %0d saturated",
             item_cnt, res_cnt, oov_cnt, sat_cnt);
    $display("weights swept across both extremes, zero, one and random values");
    if (fail_cnt == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
hdl/llr_pkg.sv
hdl/llr_cosine.sv
hdl/llr_div.sv
hdl/lunar_lambert_reflectance_unit.sv
hdl/llr_checker.sv
tb/lunar_lambert_reflectance_unit_tb.sv
